// ----- hw/rtl/jssc_pkg.sv -----
`timescale 1ns / 1ps

package jssc_pkg;

	// Sample and register widths.
	localparam int SAMPLE_W = 12;
	localparam int AVG_WINDOW = 2;
	localparam logic [SAMPLE_W-1:0] FULL_SCALE = 12'hFFF;

	// Steering map.
	localparam logic [8:0] DEG_FULL = 9'd360;
	localparam logic [8:0] DEG_CENTER = 9'd180;
	localparam logic [8:0] STEER_CENTER_DZ = 9'd8;
	localparam logic [8:0] STEER_STEP = 9'd5;
	localparam logic [8:0] STEP_HALF = 9'd2;
	// x / 5 == (x * 205) >> 10 for every x the rounding stage can see (x <= 362).
	localparam logic [7:0] STEP_RECIP = 8'd205;
	localparam int STEP_SHIFT = 10;
	localparam int STEP_PROD_W = 17;
	localparam int STEP_QUO_W = 7;

	// Speed map.
	localparam logic [7:0] SPEED_TOP = 8'd255;
	localparam logic [SAMPLE_W-1:0] SPEED_EDGE_DZ = 12'd80;
	localparam logic [SAMPLE_W:0] SPEED_SPAN_MIN = 13'(2 * SPEED_EDGE_DZ);

	// Serial divider: every quotient fits in nine bits, so nine steps suffice.
	localparam int DIV_NUM_W = 21;
	localparam int DIV_Q_W = 9;
	localparam int DIV_CNT_W = 4;

	// Register indexes (paddr[3:2]).
	localparam logic [1:0] REG_STEER_MIN = 2'd0;
	localparam logic [1:0] REG_STEER_MAX = 2'd1;
	localparam logic [1:0] REG_SPEED_MIN = 2'd2;
	localparam logic [1:0] REG_SPEED_MAX = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG,
		ST_PREP,
		ST_STEER_DIV,
		ST_STEER_WAIT,
		ST_STEER_POST,
		ST_SPEED_DIV,
		ST_SPEED_WAIT,
		ST_SPEED_POST,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic ready;
		logic calc_avg;
		logic prep;
		logic div_start;
		logic div_speed;
		logic steer_post;
		logic speed_post;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic in_accept;
		logic div_done;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] steer_min;
		logic [SAMPLE_W-1:0] steer_max;
		logic [SAMPLE_W-1:0] speed_min;
		logic [SAMPLE_W-1:0] speed_max;
	} cfg_t;

endpackage

// ----- hw/rtl/jssc_div.sv -----
`timescale 1ns / 1ps

module jssc_div import jssc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [SAMPLE_W-1:0]  den,
	output logic                 busy,
	output logic                 done,
	output logic [DIV_Q_W-1:0]   quo
);

	logic [SAMPLE_W-1:0]  rem_q;
	logic [DIV_Q_W-1:0]   shf_q;
	logic [SAMPLE_W-1:0]  den_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [SAMPLE_W:0]    trial;
	logic [SAMPLE_W:0]    diff;
	logic                 ge;

	// Restoring division, one quotient bit a cycle. The numerator's low bits
	// shift out of shf_q while the quotient bits shift in behind them.
	assign trial = {rem_q, shf_q[DIV_Q_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num[DIV_NUM_W-1:DIV_Q_W];
			shf_q <= num[DIV_Q_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
			shf_q <= {shf_q[DIV_Q_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = shf_q;

endmodule

// ----- hw/rtl/jssc_ctrl.sv -----
`timescale 1ns / 1ps

module jssc_ctrl import jssc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:       if (sts.in_accept) state_d = ST_AVG;
			ST_AVG:        state_d = ST_PREP;
			ST_PREP:       state_d = ST_STEER_DIV;
			ST_STEER_DIV:  state_d = ST_STEER_WAIT;
			ST_STEER_WAIT: if (sts.div_done) state_d = ST_STEER_POST;
			ST_STEER_POST: state_d = ST_SPEED_DIV;
			ST_SPEED_DIV:  state_d = ST_SPEED_WAIT;
			ST_SPEED_WAIT: if (sts.div_done) state_d = ST_SPEED_POST;
			ST_SPEED_POST: state_d = ST_DONE;
			ST_DONE:       if (sts.out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:       cmd.ready = 1'b1;
			ST_AVG:        cmd.calc_avg = 1'b1;
			ST_PREP:       cmd.prep = 1'b1;
			ST_STEER_DIV:  cmd.div_start = 1'b1;
			ST_STEER_WAIT: cmd = '0;
			ST_STEER_POST: cmd.steer_post = 1'b1;
			ST_SPEED_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_speed = 1'b1;
			end
			ST_SPEED_WAIT: cmd = '0;
			ST_SPEED_POST: cmd.speed_post = 1'b1;
			ST_DONE:       cmd.out_load = sts.out_free;
			default:       cmd = '0;
		endcase
	end

endmodule

// ----- hw/rtl/jssc_dp.sv -----
`timescale 1ns / 1ps

module jssc_dp import jssc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata
);

	typedef enum logic [1:0] {
		LVL_DIV,
		LVL_ZERO,
		LVL_TOP
	} lvl_cls_t;

	logic                in_acc;
	logic [SAMPLE_W-1:0] in_steer;
	logic [SAMPLE_W-1:0] in_speed;
	logic                in_dir;

	logic [SAMPLE_W-1:0] steer_hist_q [AVG_WINDOW];
	logic [SAMPLE_W-1:0] speed_hist_q [AVG_WINDOW];
	logic                slot_q;
	logic [1:0]          frame_q;
	logic                warm_q;
	logic                dir_q;

	logic [SAMPLE_W:0]   steer_sum;
	logic [SAMPLE_W:0]   speed_sum;
	logic [SAMPLE_W-1:0] steer_avg_q;
	logic [SAMPLE_W-1:0] speed_avg_q;

	logic                st_bad;
	logic [SAMPLE_W-1:0] st_lo;
	logic [SAMPLE_W-1:0] st_hi;
	logic [SAMPLE_W-1:0] st_x;
	logic                sp_bad;
	logic [SAMPLE_W-1:0] sp_lo;
	logic [SAMPLE_W-1:0] sp_hi;
	logic [SAMPLE_W-1:0] sp_x;
	logic                sp_narrow;
	logic [SAMPLE_W-1:0] sp_dlo;
	logic [SAMPLE_W-1:0] sp_dhi;

	logic [SAMPLE_W-1:0] st_off_q;
	logic [SAMPLE_W-1:0] st_den_q;
	logic [SAMPLE_W-1:0] sp_off_q;
	logic [SAMPLE_W-1:0] sp_den_q;
	lvl_cls_t            sp_cls_q;

	logic [DIV_NUM_W-1:0] div_num;
	logic [SAMPLE_W-1:0]  div_den;
	logic                 div_busy;
	logic                 div_done;
	logic [DIV_Q_W-1:0]   div_quo;

	logic [8:0]             deg_snap;
	logic [9:0]             deg_rnd;
	logic [STEP_PROD_W-1:0] deg_prod;
	logic [8:0]             deg_step;
	logic [8:0]             deg_q;
	logic [7:0]             lvl_q;

	logic                m_tvalid_q;
	logic [SAMPLE_W-1:0] o_steer_avg_q;
	logic [SAMPLE_W-1:0] o_speed_avg_q;
	logic [8:0]          o_deg_q;
	logic [7:0]          o_lvl_q;
	logic                o_dir_q;

	assign in_steer = s_tdata[11:0];
	assign in_speed = s_tdata[23:12];
	assign in_dir   = s_tdata[24];
	assign s_tready = cmd.ready;
	assign in_acc   = s_tvalid && cmd.ready;

	// History ring, slot pointer and warm-up counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AVG_WINDOW; i++) begin
				steer_hist_q[i] <= '0;
				speed_hist_q[i] <= '0;
			end
			slot_q  <= 1'b0;
			frame_q <= 2'd0;
			warm_q  <= 1'b1;
		end else if (in_acc) begin
			steer_hist_q[slot_q] <= in_steer;
			speed_hist_q[slot_q] <= in_speed;
			slot_q  <= ~slot_q;
			warm_q  <= (frame_q != 2'd2);
			if (frame_q != 2'd2) begin
				frame_q <= frame_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			dir_q <= in_dir;
		end
	end

	// Two-entry average: the sum halved with truncation.
	assign steer_sum = {1'b0, steer_hist_q[0]} + {1'b0, steer_hist_q[1]};
	assign speed_sum = {1'b0, speed_hist_q[0]} + {1'b0, speed_hist_q[1]};

	always_ff @(posedge clk) begin
		if (cmd.calc_avg) begin
			steer_avg_q <= steer_sum[SAMPLE_W:1];
			speed_avg_q <= speed_sum[SAMPLE_W:1];
		end
	end

	// Calibration fallback, clamping and span selection.
	always_comb begin
		st_bad = cfg.steer_max <= cfg.steer_min;
		st_lo  = st_bad ? '0 : cfg.steer_min;
		st_hi  = st_bad ? FULL_SCALE : cfg.steer_max;
		if (steer_avg_q < st_lo) begin
			st_x = st_lo;
		end else if (steer_avg_q > st_hi) begin
			st_x = st_hi;
		end else begin
			st_x = steer_avg_q;
		end

		sp_bad = cfg.speed_max <= cfg.speed_min;
		sp_lo  = sp_bad ? '0 : cfg.speed_min;
		sp_hi  = sp_bad ? FULL_SCALE : cfg.speed_max;
		if (speed_avg_q < sp_lo) begin
			sp_x = sp_lo;
		end else if (speed_avg_q > sp_hi) begin
			sp_x = sp_hi;
		end else begin
			sp_x = speed_avg_q;
		end
		sp_narrow = ({1'b0, sp_lo} + SPEED_SPAN_MIN) >= {1'b0, sp_hi};
		sp_dlo    = sp_lo + SPEED_EDGE_DZ;
		sp_dhi    = sp_hi - SPEED_EDGE_DZ;
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			st_off_q <= st_x - st_lo;
			st_den_q <= st_hi - st_lo;
			if (sp_narrow) begin
				sp_off_q <= sp_x - sp_lo;
				sp_den_q <= sp_hi - sp_lo;
				sp_cls_q <= LVL_DIV;
			end else begin
				sp_off_q <= sp_x - sp_dlo;
				sp_den_q <= sp_dhi - sp_dlo;
				if (sp_x <= sp_dlo) begin
					sp_cls_q <= LVL_ZERO;
				end else if (sp_x >= sp_dhi) begin
					sp_cls_q <= LVL_TOP;
				end else begin
					sp_cls_q <= LVL_DIV;
				end
			end
		end
	end

	// The scaled offset goes straight into the divider's registers.
	assign div_num = cmd.div_speed ? DIV_NUM_W'(sp_off_q) * DIV_NUM_W'(SPEED_TOP)
	                               : DIV_NUM_W'(st_off_q) * DIV_NUM_W'(DEG_FULL);
	assign div_den = cmd.div_speed ? sp_den_q : st_den_q;

	jssc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Center snap, rounding to the step and the cap at full scale.
	always_comb begin
		if (({1'b0, div_quo} + {1'b0, STEER_CENTER_DZ}) >= {1'b0, DEG_CENTER} &&
		    div_quo <= DEG_CENTER + STEER_CENTER_DZ) begin
			deg_snap = DEG_CENTER;
		end else begin
			deg_snap = div_quo;
		end
		deg_rnd  = {1'b0, deg_snap} + {1'b0, STEP_HALF};
		deg_prod = STEP_PROD_W'(deg_rnd) * STEP_PROD_W'(STEP_RECIP);
		deg_step = 9'(deg_prod[STEP_SHIFT +: STEP_QUO_W]) * STEER_STEP;
	end

	always_ff @(posedge clk) begin
		if (cmd.steer_post) begin
			deg_q <= (deg_step > DEG_FULL) ? DEG_FULL : deg_step;
		end
		if (cmd.speed_post) begin
			case (sp_cls_q)
				LVL_ZERO: lvl_q <= '0;
				LVL_TOP:  lvl_q <= SPEED_TOP;
				default:  lvl_q <= div_quo[7:0];
			endcase
		end
	end

	// Output register: frees the engine while a result waits downstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_steer_avg_q <= warm_q ? '0 : steer_avg_q;
			o_speed_avg_q <= warm_q ? '0 : speed_avg_q;
			o_deg_q       <= warm_q ? DEG_CENTER : deg_q;
			o_lvl_q       <= warm_q ? '0 : lvl_q;
			o_dir_q       <= dir_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, o_dir_q, o_lvl_q, o_deg_q, o_speed_avg_q, o_steer_avg_q};

	assign sts.in_accept = in_acc;
	assign sts.div_done  = div_done;
	assign sts.out_free  = !m_tvalid_q || m_tready;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider started while busy");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> m_tvalid)
		else $error("loaded result not presented");

	a_steer_quo: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.steer_post |-> div_quo <= DEG_FULL)
		else $error("steer quotient out of range");

	a_deg_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[32:24] <= DEG_FULL)
		else $error("steer angle above full scale");

	a_frame_sat: assert property (@(posedge clk) disable iff (!arst_n)
		frame_q <= 2'd2)
		else $error("warm-up counter past saturation");

endmodule

// ----- hw/rtl/joystick_steer_speed_conditioner.sv -----
// Flow: an accepted beat runs two nine-step passes of one shared serial divider (steer angle,
// then speed level) before its result is loaded into the output register; a new beat is
// taken only once the previous one has left the engine for that register.
// Reset: arst_n clears the history, warm-up count, state machine and output valid at once,
// and sets the calibration registers to 0..4095; there is no clearing pass.
`timescale 1ns / 1ps

module joystick_steer_speed_conditioner import jssc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// APB-style configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	// [11:0] steer_sample, [23:12] speed_sample, [24] direction_pin, [31:25] zero
	input  logic [31:0] s_tdata,
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	// [11:0] steer_average, [23:12] speed_average, [32:24] steer_degrees,
	// [40:33] speed_level, [41] direction_out, [47:42] zero
	output logic [47:0] m_tdata
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic cfg_wr;

	// The port never stalls. A register is written in the access phase of a
	// write; the word address picks the register, the low address bits are
	// ignored and only the low twelve data bits are kept.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.steer_min <= '0;
			cfg_q.steer_max <= FULL_SCALE;
			cfg_q.speed_min <= '0;
			cfg_q.speed_max <= FULL_SCALE;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_STEER_MIN: cfg_q.steer_min <= pwdata[SAMPLE_W-1:0];
				REG_STEER_MAX: cfg_q.steer_max <= pwdata[SAMPLE_W-1:0];
				REG_SPEED_MIN: cfg_q.speed_min <= pwdata[SAMPLE_W-1:0];
				REG_SPEED_MAX: cfg_q.speed_max <= pwdata[SAMPLE_W-1:0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end

	// Reads return the stored value even when a pair is inverted; the
	// fallback to the full 0..4095 span happens only where the pair is used.
	always_comb begin
		unique case (paddr[3:2])
			REG_STEER_MIN: prdata = 32'(cfg_q.steer_min);
			REG_STEER_MAX: prdata = 32'(cfg_q.steer_max);
			REG_SPEED_MIN: prdata = 32'(cfg_q.speed_min);
			REG_SPEED_MAX: prdata = 32'(cfg_q.speed_max);
			default:       prdata = '0;
		endcase
	end

	// The controller steps one beat through averaging, calibration, the
	// steer divide and the speed divide; the datapath holds every value.
	jssc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// During the first two beats after reset the result is forced to the
	// centered, stopped values while the averaging history still fills.
	jssc_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.cmd      (cmd),
		.sts      (sts),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- tb/tb_joystick_steer_speed_conditioner.sv -----
`timescale 1ns / 1ps

// Shadow copy of the conditioner: it keeps its own calibration, averaging
// history and warm-up count, and holds the results still owed by the block.
class cond_scoreboard;
	typedef struct {
		int unsigned steer_avg;
		int unsigned speed_avg;
		int unsigned degrees;
		int unsigned level;
		int unsigned dir;
	} cond_result_t;

	jssc_pkg::cfg_t cfg;
	logic [11:0] steer_hist [2];
	logic [11:0] speed_hist [2];
	bit ring_slot;
	int unsigned frames;
	cond_result_t owed [$];
	int failures;

	function new();
		cfg.steer_min = 12'd0;
		cfg.steer_max = 12'd4095;
		cfg.speed_min = 12'd0;
		cfg.speed_max = 12'd4095;
		steer_hist = '{default: 12'd0};
		speed_hist = '{default: 12'd0};
		ring_slot = 1'b0;
		frames = 0;
		failures = 0;
	endfunction

	function void report(string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		failures++;
	endfunction

	function int pending();
		return owed.size();
	endfunction

	function void write_reg(logic [1:0] idx, logic [11:0] value);
		case (idx)
			jssc_pkg::REG_STEER_MIN: cfg.steer_min = value;
			jssc_pkg::REG_STEER_MAX: cfg.steer_max = value;
			jssc_pkg::REG_SPEED_MIN: cfg.speed_min = value;
			jssc_pkg::REG_SPEED_MAX: cfg.speed_max = value;
		endcase
	endfunction

	// Truncating linear map of x from lo..hi onto 0..top; an empty span gives 0.
	function int unsigned span_map(int unsigned x, int unsigned lo, int unsigned hi,
			int unsigned top);
		if (hi <= lo)
			return 0;
		if (x < lo)
			x = lo;
		if (x > hi)
			x = hi;
		return ((x - lo) * top) / (hi - lo);
	endfunction

	function int unsigned angle_of(int unsigned avg);
		int unsigned lo;
		int unsigned hi;
		int unsigned deg;
		lo = cfg.steer_min;
		hi = cfg.steer_max;
		if (hi <= lo) begin
			lo = 0;
			hi = jssc_pkg::FULL_SCALE;
		end
		deg = span_map(avg, lo, hi, jssc_pkg::DEG_FULL);
		if (deg + jssc_pkg::STEER_CENTER_DZ >= jssc_pkg::DEG_CENTER &&
				deg <= jssc_pkg::DEG_CENTER + jssc_pkg::STEER_CENTER_DZ)
			deg = jssc_pkg::DEG_CENTER;
		deg = ((deg + jssc_pkg::STEP_HALF) / jssc_pkg::STEER_STEP) * jssc_pkg::STEER_STEP;
		if (deg > jssc_pkg::DEG_FULL)
			deg = jssc_pkg::DEG_FULL;
		return deg;
	endfunction

	function int unsigned level_of(int unsigned avg);
		int unsigned lo;
		int unsigned hi;
		int unsigned dz;
		lo = cfg.speed_min;
		hi = cfg.speed_max;
		dz = jssc_pkg::SPEED_EDGE_DZ;
		if (hi <= lo) begin
			lo = 0;
			hi = jssc_pkg::FULL_SCALE;
		end
		if (avg < lo)
			avg = lo;
		if (avg > hi)
			avg = hi;
		// Too narrow for two dead zones: map the whole span instead.
		if (lo + 2 * dz >= hi)
			return span_map(avg, lo, hi, jssc_pkg::SPEED_TOP);
		if (avg <= lo + dz)
			return 0;
		if (avg >= hi - dz)
			return jssc_pkg::SPEED_TOP;
		return span_map(avg, lo + dz, hi - dz, jssc_pkg::SPEED_TOP);
	endfunction

	function void note_input(logic [11:0] steer, logic [11:0] speed, logic pin);
		cond_result_t r;
		int unsigned st_avg;
		int unsigned sp_avg;
		steer_hist[ring_slot] = steer;
		speed_hist[ring_slot] = speed;
		ring_slot = ~ring_slot;
		st_avg = (int'(steer_hist[0]) + int'(steer_hist[1])) / jssc_pkg::AVG_WINDOW;
		sp_avg = (int'(speed_hist[0]) + int'(speed_hist[1])) / jssc_pkg::AVG_WINDOW;
		if (frames < 2) begin
			r.steer_avg = 0;
			r.speed_avg = 0;
			r.degrees = jssc_pkg::DEG_CENTER;
			r.level = 0;
			frames++;
		end else begin
			r.steer_avg = st_avg;
			r.speed_avg = sp_avg;
			r.degrees = angle_of(st_avg);
			r.level = level_of(sp_avg);
		end
		r.dir = pin;
		owed.push_back(r);
	endfunction

	function void compare(string name, int unsigned got, int unsigned want);
		if (got != want)
			report($sformatf("%s is %0d, expected %0d", name, got, want));
	endfunction

	function void check_result(logic [47:0] d);
		cond_result_t r;
		if (owed.size() == 0) begin
			report($sformatf("result beat 0x%012h arrived with nothing outstanding", d));
			return;
		end
		r = owed.pop_front();
		compare("steer_average", d[11:0], r.steer_avg);
		compare("speed_average", d[23:12], r.speed_avg);
		compare("steer_degrees", d[32:24], r.degrees);
		compare("speed_level", d[40:33], r.level);
		compare("direction_out", d[41], r.dir);
	endfunction
endclass

module tb_joystick_steer_speed_conditioner;
	import jssc_pkg::*;

	// Idle margin that a drain waits once no result is owed.
	localparam int SETTLE_CYCLES = 40;
	// The slowest legal run is roughly 500 beats of divider work, the sender's idle gaps
	// and long receiver stalls, plus the drains.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PER_PHASE = 70;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid;
	logic s_tready;
	// [11:0] steer_sample, [23:12] speed_sample, [24] direction_pin, [31:25] zero
	logic [31:0] s_tdata;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// [11:0] steer_average, [23:12] speed_average, [32:24] steer_degrees,
	// [40:33] speed_level, [41] direction_out, [47:42] zero
	logic [47:0] m_tdata;

	cond_scoreboard sb = new();
	int cycles = 0;
	int burst_left = 0;
	logic [11:0] last_steer = 12'd0;
	logic [11:0] last_speed = 12'd0;

	joystick_steer_speed_conditioner dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: a hung handshake must not hang the run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// The receiver moves between three moods in turn: always ready,
	// a coin toss per cycle, and mostly stalled, so back-pressure lands on
	// every phase of the block's divider sequence.
	always @(posedge clk) begin
		case ((cycles / 256) % 3)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// Both handshakes are sampled at the clock edge before any of this edge's
	// updates land, so the check sees exactly the beats the block saw.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
			if (s_tvalid && s_tready)
				sb.note_input(s_tdata[11:0], s_tdata[23:12], s_tdata[24]);
		end
	end

	// One APB write: a setup phase, then the access phase that completes on pready.
	// The upper data bits carry noise, since the registers keep only 12 bits.
	task automatic apb_write(logic [1:0] idx, logic [11:0] value);
		logic [31:0] noise;
		noise = $urandom();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {noise[31:12], value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Offers one beat. The sender works in bursts; at the start of each burst it
	// may drop tvalid for a random gap, sometimes long enough to span a whole
	// divider pass. A zero gap keeps tvalid high straight through.
	task automatic send_sample(logic [11:0] steer, logic [11:0] speed, logic pin);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, pin, speed, steer};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		last_steer = steer;
		last_speed = speed;
	endtask

	// Stops offering beats and waits until the block owes nothing; the block is
	// then idle and its calibration may be rewritten. The first edge lets the
	// monitor note the beat accepted at the edge the sender just left.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_calibration(logic [11:0] st_lo, logic [11:0] st_hi,
			logic [11:0] sp_lo, logic [11:0] sp_hi);
		apb_write(REG_STEER_MIN, st_lo);
		apb_write(REG_STEER_MAX, st_hi);
		apb_write(REG_SPEED_MIN, sp_lo);
		apb_write(REG_SPEED_MAX, sp_hi);
	endtask

	// Sample picker aimed at the interesting regions: failed conversions (zero),
	// full scale, both calibration edges and their dead zones, mid span, and
	// plain uniform noise.
	function automatic logic [11:0] pick_sample(int lo, int hi);
		int v;
		case ($urandom_range(0, 9))
			0: v = 0;
			1: v = 4095;
			2: v = lo + int'($urandom_range(0, 240)) - 120;
			3: v = hi + int'($urandom_range(0, 240)) - 120;
			4: v = (lo + hi) / 2 + int'($urandom_range(0, 160)) - 80;
			5, 6: v = $urandom_range(0, 4095);
			default: v = (lo < hi) ? $urandom_range(lo, hi) : $urandom_range(0, 4095);
		endcase
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return 12'(v);
	endfunction

	// Random beats for one calibration. A sample often repeats the previous one,
	// so the two-entry average settles on a chosen value and the map is probed at
	// exact points; the rest mixes fresh values for averages of unlike pairs.
	task automatic random_samples(int count, int st_lo, int st_hi, int sp_lo, int sp_hi,
			bit hold_off);
		logic [11:0] steer;
		logic [11:0] speed;
		for (int i = 0; i < count; i++) begin
			steer = ($urandom_range(0, 2) == 0) ? last_steer : pick_sample(st_lo, st_hi);
			speed = ($urandom_range(0, 2) == 0) ? last_speed : pick_sample(sp_lo, sp_hi);
			send_sample(steer, speed, 1'($urandom_range(0, 1)));
			// Once in the run, the sender holds off until the block owes nothing.
			if (hold_off && i == count / 2)
				drain_results();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 4'd0;
		pwdata <= 32'd0;
		s_tvalid <= 1'b0;
		s_tdata <= 32'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, on the reset calibration of 0..4095. The first two beats
		// fall in the warm-up and must give the neutral result with the pin copied.
		send_sample(12'd4095, 12'd4095, 1'b1);
		send_sample(12'd0, 12'd0, 1'b0);
		// Zero settled, then the truncating average of zero and full scale, then full scale settled.
		send_sample(12'd0, 12'd0, 1'b1);
		send_sample(12'd4095, 12'd4095, 1'b0);
		send_sample(12'd4095, 12'd4095, 1'b1);
		// Steer around the centre snap window and speed around both dead zones;
		// each value is sent twice so the average lands on it exactly.
		send_sample(12'd1945, 12'd80, 1'b0);
		send_sample(12'd1945, 12'd80, 1'b1);
		send_sample(12'd1957, 12'd81, 1'b0);
		send_sample(12'd1957, 12'd81, 1'b1);
		send_sample(12'd2047, 12'd2048, 1'b0);
		send_sample(12'd2047, 12'd2048, 1'b1);
		send_sample(12'd2138, 12'd4014, 1'b0);
		send_sample(12'd2138, 12'd4014, 1'b1);
		send_sample(12'd2150, 12'd4015, 1'b0);
		send_sample(12'd2150, 12'd4015, 1'b1);
		send_sample(12'd2161, 12'd40, 1'b0);
		send_sample(12'd2161, 12'd40, 1'b1);
		// A few settled values that sit between rounding steps of five degrees.
		send_sample(12'd34, 12'd4060, 1'b0);
		send_sample(12'd34, 12'd4060, 1'b1);
		send_sample(12'd4080, 12'd1, 1'b0);
		send_sample(12'd4080, 12'd1, 1'b1);
		drain_results();

		// Random part, one calibration per phase. Each phase starts from an idle
		// block: every result is in before the registers change.
		random_samples(RANDOM_PER_PHASE, 0, 4095, 0, 4095, 1'b0);
		drain_results();

		// Ordinary interior calibration.
		load_calibration(12'd1000, 12'd3000, 12'd500, 12'd3500);
		random_samples(RANDOM_PER_PHASE, 1000, 3000, 500, 3500, 1'b1);
		drain_results();

		// Inverted steer pair and an empty speed pair both fall back to full scale.
		load_calibration(12'd3000, 12'd1000, 12'd2000, 12'd2000);
		random_samples(RANDOM_PER_PHASE, 0, 4095, 0, 4095, 1'b0);
		drain_results();

		// A one-count speed span at the top of the range: too narrow for dead zones.
		load_calibration(12'd0, 12'd4095, 12'd4094, 12'd4095);
		random_samples(RANDOM_PER_PHASE, 0, 4095, 4094, 4095, 1'b0);
		drain_results();

		// Steer pair equal at full scale, and a speed maximum below the dead zone.
		load_calibration(12'd4095, 12'd4095, 12'd0, 12'd70);
		random_samples(RANDOM_PER_PHASE, 0, 4095, 0, 70, 1'b0);
		drain_results();

		// One-count steer span; speed span exactly two dead zones wide (narrow).
		load_calibration(12'd0, 12'd1, 12'd1000, 12'd1160);
		random_samples(RANDOM_PER_PHASE, 0, 1, 1000, 1160, 1'b0);
		drain_results();

		// Speed span one count wider than two dead zones, so the zones apply.
		load_calibration(12'd100, 12'd4000, 12'd1000, 12'd1161);
		random_samples(RANDOM_PER_PHASE, 100, 4000, 1000, 1161, 1'b0);
		drain_results();

		if (sb.failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
